// ----- hw/rtl/tcpwm_pkg.sv -----
// shared types and constants for the two-channel sensor to pwm drive
package tcpwm_pkg;

   localparam int DUTY_W    = 7;
   localparam int QUO_BITS  = 7;
   localparam int CSR_IDX_W = 3;

   typedef logic [DUTY_W-1:0]    duty_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam duty_type FULL_SCALE   = 7'd100;
   localparam duty_type PWM_PERIOD   = 7'd100;
   localparam duty_type CUTOFF_RESET = 7'd45;
   localparam duty_type CAP_RESET    = 7'd50;

   localparam csr_idx_type CSR_MIN_A      = 3'd0;
   localparam csr_idx_type CSR_MAX_A      = 3'd1;
   localparam csr_idx_type CSR_MIN_B      = 3'd2;
   localparam csr_idx_type CSR_MAX_B      = 3'd3;
   localparam csr_idx_type CSR_LOW_CUTOFF = 3'd4;
   localparam csr_idx_type CSR_HIGH_CAP   = 3'd5;

   typedef struct packed {
      duty_type cutoff;
      duty_type cap;
   } limit_type;

endpackage

// ----- hw/rtl/two_channel_sensor_to_pwm_drive_top.sv -----
// top level: config registers, two duty lanes, merge of duties, pwm and result register
// a tick item goes straight to report after transfer, a sample item runs through
// (capture, prepare, 7-bit quotient of the lane divider, finish, report)
// one item at a time: the next transfer is taken once the result is in the output register
// the output register frees on its own transfer, so a new item runs while a result waits
// synchronous active-high reset: config to 0 / cutoff 45 / cap 50, counter, duties and drives 0
module two_channel_sensor_to_pwm_drive_top #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [SAMPLE_BITS-1:0]       req_sample_a,
   input  logic [SAMPLE_BITS-1:0]       req_sample_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_motor_a_on,
   output logic                         rsp_motor_b_on,
   output tcpwm_pkg::duty_type          rsp_duty_a_now,
   output tcpwm_pkg::duty_type          rsp_duty_b_now,
   input  logic                         csr_wr_en,
   input  tcpwm_pkg::csr_idx_type       csr_index,
   input  logic [SAMPLE_BITS-1:0]       csr_wdata
);
   import tcpwm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CALC   = 3'b010,
      S_REPORT = 3'b100
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [SAMPLE_BITS-1:0] min_a_ff, max_a_ff, min_b_ff, max_b_ff;
   duty_type               cutoff_ff, cap_ff;
   duty_type               speed_a_ff, speed_a_in;
   duty_type               speed_b_ff, speed_b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   motor_a_ff, motor_b_ff;
   duty_type               duty_a_ff, duty_b_ff;
   logic                   req_xfer;
   logic                   out_free;
   logic                   load_out;
   logic                   lane_start;
   logic                   tick;
   logic                   done_a, done_b;
   duty_type               lane_duty_a, lane_duty_b;
   logic                   drive_a, drive_b;
   limit_type              limits;

   assign req_stall = state_ff != S_IDLE;
   assign req_xfer  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign lane_start = req_xfer & ~req_type;
   assign tick       = req_xfer & req_type;
   assign limits     = '{cutoff: cutoff_ff, cap: cap_ff};

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_a_ff  <= '0;
         max_a_ff  <= '0;
         min_b_ff  <= '0;
         max_b_ff  <= '0;
         cutoff_ff <= CUTOFF_RESET;
         cap_ff    <= CAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_A:      min_a_ff  <= csr_wdata;
            CSR_MAX_A:      max_a_ff  <= csr_wdata;
            CSR_MIN_B:      min_b_ff  <= csr_wdata;
            CSR_MAX_B:      max_b_ff  <= csr_wdata;
            CSR_LOW_CUTOFF: cutoff_ff <= csr_wdata[DUTY_W-1:0];
            CSR_HIGH_CAP:   cap_ff    <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   tcpwm_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_a (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .sample(req_sample_a),
      .lo    (min_a_ff),
      .hi    (max_a_ff),
      .limits(limits),
      .done  (done_a),
      .duty  (lane_duty_a)
   );

   tcpwm_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_b (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .sample(req_sample_b),
      .lo    (min_b_ff),
      .hi    (max_b_ff),
      .limits(limits),
      .done  (done_b),
      .duty  (lane_duty_b)
   );

   tcpwm_pwm u_pwm (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .speed_a(speed_a_ff),
      .speed_b(speed_b_ff),
      .drive_a(drive_a),
      .drive_b(drive_b)
   );

   // sequencing and merge of the lane duties
   always_comb begin
      state_in   = state_ff;
      speed_a_in = speed_a_ff;
      speed_b_in = speed_b_ff;
      load_out   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (tick) begin
               state_in = S_REPORT;
            end else if (lane_start) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (done_a & done_b) begin
               speed_a_in = lane_duty_a;
               speed_b_in = lane_duty_b;
               state_in   = S_REPORT;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         speed_a_ff   <= '0;
         speed_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_a_ff   <= speed_a_in;
         speed_b_ff   <= speed_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, held while the transfer is stalled
   always_ff @(posedge clock) begin
      if (load_out) begin
         motor_a_ff <= drive_a;
         motor_b_ff <= drive_b;
         duty_a_ff  <= speed_a_ff;
         duty_b_ff  <= speed_b_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_motor_a_on = motor_a_ff;
   assign rsp_motor_b_on = motor_b_ff;
   assign rsp_duty_a_now = duty_a_ff;
   assign rsp_duty_b_now = duty_b_ff;

endmodule

// ----- hw/rtl/tcpwm_lane.sv -----
// one duty lane: clamp, scale and iterative restoring division to a limited duty
module tcpwm_lane #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   lo,
   input  logic [SAMPLE_BITS-1:0]   hi,
   input  tcpwm_pkg::limit_type     limits,
   output logic                     done,
   output tcpwm_pkg::duty_type      duty
);
   import tcpwm_pkg::*;

   localparam int NumW = SAMPLE_BITS + QUO_BITS;
   localparam int BitW = $clog2(QUO_BITS);

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_PREP = 4'b0010,
      L_DIV  = 4'b0100,
      L_FIN  = 4'b1000
   } lane_state_type;

   lane_state_type         state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0] span_ff, span_in;
   logic [NumW-1:0]        num_ff, num_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic [BitW-1:0]        bit_ff, bit_in;
   logic                   zero_ff, zero_in;
   logic [SAMPLE_BITS-1:0] clamped;
   logic [NumW-1:0]        span_sh;
   logic                   fits;
   duty_type               raw;

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      span_in   = span_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      bit_in    = bit_ff;
      zero_in   = zero_ff;
      clamped   = sample_ff;
      span_sh   = NumW'(span_ff) << bit_ff;
      fits      = num_ff >= span_sh;
      done      = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               sample_in = sample;
               lo_in     = lo;
               hi_in     = hi;
               state_in  = L_PREP;
            end
         end
         L_PREP: begin
            if (sample_ff > hi_ff) begin
               clamped = hi_ff;
            end
            if (clamped < lo_ff) begin
               clamped = lo_ff;
            end
            num_in   = NumW'(clamped - lo_ff) * NumW'(FULL_SCALE);
            span_in  = hi_ff - lo_ff;
            zero_in  = hi_ff <= lo_ff;
            quo_in   = '0;
            bit_in   = BitW'(QUO_BITS - 1);
            state_in = L_DIV;
         end
         L_DIV: begin
            if (fits) begin
               num_in = num_ff - span_sh;
            end
            quo_in = {quo_ff[QUO_BITS-2:0], fits};
            if (bit_ff == '0) begin
               state_in = L_FIN;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         L_FIN: begin
            done     = 1'b1;
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   // duty limiting on the finished quotient
   always_comb begin
      raw = FULL_SCALE - DUTY_W'(quo_ff);
      if (raw <= limits.cutoff) begin
         raw = '0;
      end
      if (raw >= limits.cap) begin
         raw = limits.cap;
      end
      duty = zero_ff ? '0 : raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      span_ff   <= span_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      bit_ff    <= bit_in;
      zero_ff   <= zero_in;
   end

endmodule

// ----- hw/rtl/tcpwm_pwm.sv -----
// pwm period counter and the two motor drive levels
module tcpwm_pwm (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  tcpwm_pkg::duty_type speed_a,
   input  tcpwm_pkg::duty_type speed_b,
   output logic                drive_a,
   output logic                drive_b
);
   import tcpwm_pkg::*;

   duty_type count_ff, count_in;
   logic     drive_a_ff, drive_a_in;
   logic     drive_b_ff, drive_b_in;

   always_comb begin
      count_in   = count_ff;
      drive_a_in = drive_a_ff;
      drive_b_in = drive_b_ff;
      if (tick) begin
         count_in = count_ff + 1'b1;
         if (count_in >= PWM_PERIOD) begin
            count_in   = '0;
            drive_a_in = 1'b1;
            drive_b_in = 1'b1;
         end
         if (count_in == speed_a) begin
            drive_a_in = 1'b0;
         end
         if (count_in == speed_b) begin
            drive_b_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drive_a_ff <= 1'b0;
         drive_b_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drive_a_ff <= drive_a_in;
         drive_b_ff <= drive_b_in;
      end
   end

   assign drive_a = drive_a_ff;
   assign drive_b = drive_b_ff;

endmodule
